FILE: rtl/core/scfr_pkg.sv
package scfr_pkg;

  // Frame layout: head0, head1, command, pitch, checksum, tail
  localparam int unsigned WIN_LEN = 5;
  localparam int unsigned FILL_W  = $clog2(WIN_LEN + 1);

  localparam logic [7:0] HEAD0 = 8'hFF;
  localparam logic [7:0] HEAD1 = 8'hFE;
  localparam logic [7:0] TAIL  = 8'hA5;

  // Window positions, oldest first
  localparam int unsigned POS_HEAD0 = 0;
  localparam int unsigned POS_HEAD1 = 1;
  localparam int unsigned POS_CMD   = 2;
  localparam int unsigned POS_PITCH = 3;
  localparam int unsigned POS_SUM   = 4;

  // Command codes
  localparam logic [7:0] CMD_LINK_OPEN  = 8'd0;
  localparam logic [7:0] CMD_LINK_CLOSE = 8'd1;
  localparam logic [7:0] CMD_ARMOR      = 8'd2;
  localparam logic [7:0] CMD_BIG_RUNE   = 8'd3;
  localparam logic [7:0] CMD_SMALL_RUNE = 8'd4;

  typedef enum logic [1:0] {
    MODE_ARMOR      = 2'd0,
    MODE_BIG_RUNE   = 2'd1,
    MODE_SMALL_RUNE = 2'd2
  } mode_t;

  typedef logic [7:0] byte_t;

endpackage

FILE: rtl/core/serial_command_frame_receiver_unit.sv
// A frame's result is registered: out_valid rises in the cycle after its tail beat is accepted.
// Throughput: one byte beat per cycle; in_ready drops only while an unread result
// stalls in the output register.
// Reset (rst_n low, synchronous): empties the byte window, closes the link,
// selects armor mode and clears the output register's valid flag.
module serial_command_frame_receiver_unit
  import scfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_link_open,
  output logic [1:0]        out_vision_mode,
  output logic signed [7:0] out_pitch_quarter_deg,
  output logic [7:0]        out_command_code,
  output logic              out_unknown_command
);

  byte_t              win_r [WIN_LEN];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               link_r, link_nxt;
  mode_t              mode_r, mode_nxt;
  logic               unknown_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_link_r;
  mode_t              out_mode_r;
  byte_t              out_pitch_r;
  byte_t              out_cmd_r;
  logic               out_unknown_r;

  logic               accept;
  logic               frame_hit;
  byte_t              sum;

  // Accept while the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Check a full window's head and checksum, and the incoming beat as tail
  assign sum       = win_r[POS_CMD] + win_r[POS_PITCH];
  assign frame_hit = (fill_r == FILL_W'(WIN_LEN)) && (win_r[POS_HEAD0] == HEAD0) &&
                     (win_r[POS_HEAD1] == HEAD1) && (in_rx_byte == TAIL) &&
                     (sum == win_r[POS_SUM]);

  // Decode the command into the new settings
  always_comb begin
    link_nxt    = link_r;
    mode_nxt    = mode_r;
    unknown_nxt = 1'b0;
    unique case (win_r[POS_CMD])
      CMD_LINK_OPEN:  link_nxt = 1'b1;
      CMD_LINK_CLOSE: link_nxt = 1'b0;
      CMD_ARMOR:      mode_nxt = MODE_ARMOR;
      CMD_BIG_RUNE:   mode_nxt = MODE_BIG_RUNE;
      CMD_SMALL_RUNE: mode_nxt = MODE_SMALL_RUNE;
      default:        unknown_nxt = 1'b1;
    endcase
  end

  // Restart the hunt after a frame, else count up to a full window
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (frame_hit) begin
        fill_nxt = '0;
      end else if (fill_r != FILL_W'(WIN_LEN)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  // Hold a result until taken, load a new one on a frame
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && frame_hit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      link_r      <= 1'b0;
      mode_r      <= MODE_ARMOR;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && frame_hit) begin
        link_r <= link_nxt;
        mode_r <= mode_nxt;
      end
    end
  end

  // Shift the beat in at the young end; only a full window is ever matched
  always_ff @(posedge clk) begin
    if (accept && !frame_hit) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[WIN_LEN - 1] <= in_rx_byte;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && frame_hit) begin
      out_link_r    <= link_nxt;
      out_mode_r    <= mode_nxt;
      out_pitch_r   <= win_r[POS_PITCH];
      out_cmd_r     <= win_r[POS_CMD];
      out_unknown_r <= unknown_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_link_open         = out_link_r;
  assign out_vision_mode       = out_mode_r;
  assign out_pitch_quarter_deg = $signed(out_pitch_r);
  assign out_command_code      = out_cmd_r;
  assign out_unknown_command   = out_unknown_r;

`ifndef SYNTHESIS
  a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN_LEN))
    else $error("window fill beyond its length");

  a_hit_empties : assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_hit |=> fill_r == '0 && out_valid_r)
    else $error("frame did not restart the hunt or raise a result");

  a_miss_counts : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !frame_hit && fill_r != FILL_W'(WIN_LEN) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("window fill did not advance");

  a_unknown_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_unknown_r == (out_cmd_r > CMD_SMALL_RUNE))
    else $error("unknown command flag disagrees with command code");

  a_no_hit_short : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != FILL_W'(WIN_LEN) |-> !frame_hit)
    else $error("frame matched on a short window");
`endif

endmodule
